/* hdl/scs_pkg.sv */
// ----------------------------------------------------------------------------
// Scaled cosine sample generator: shared definitions
// Widths, CORDIC constants, register indexes and the word that moves from
// one CORDIC cell to the next.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Phase resolution and CORDIC depth.
  localparam int PHASE_BITS        = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CELL_COUNT        = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int STEP_W            = $clog2(ATAN_ENTRIES);

  // Field widths.
  localparam int TIME_W   = 32;
  localparam int FREQ_W   = 32;
  localparam int AMP_W    = 16;
  localparam int OFFSET_W = 16;
  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Datapath widths: Q2.30 for x and y, 32-bit binary angle for z.
  localparam int CORDIC_W = 32;
  localparam int COS_W    = 16;

  // Converged CORDIC gain 0.60725293500888 in Q2.30.
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;

  // Register reset values.
  localparam logic [AMP_W-1:0]    AMP_RESET    = 16'd256;
  localparam logic [FREQ_W-1:0]   FREQ_RESET   = 32'd131072;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE    = 2'd0,
    CFG_FREQUENCY    = 2'd1,
    CFG_PHASE_OFFSET = 2'd2
  } cfg_idx_t;

  // Quadrant of the phase and the sign/axis it maps to.
  typedef enum logic [1:0] {
    QUAD_COS     = 2'd0,
    QUAD_NEG_SIN = 2'd1,
    QUAD_NEG_COS = 2'd2,
    QUAD_SIN     = 2'd3
  } quad_t;

  // Word handed from one CORDIC cell to the next.
  typedef struct packed {
    logic                       last;
    quad_t                      quad;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_word_t;

  // atan(2^-i) in binary angle units (2^32 is one turn).
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic signed [CORDIC_W-1:0] a;
    case (idx)
      5'd0:    a = 32'sh20000000;
      5'd1:    a = 32'sh12E4051E;
      5'd2:    a = 32'sh09FB385B;
      5'd3:    a = 32'sh051111D4;
      5'd4:    a = 32'sh028B0D43;
      5'd5:    a = 32'sh0145D7E1;
      5'd6:    a = 32'sh00A2F61E;
      5'd7:    a = 32'sh00517C55;
      5'd8:    a = 32'sh0028BE53;
      5'd9:    a = 32'sh00145F2F;
      5'd10:   a = 32'sh000A2F98;
      5'd11:   a = 32'sh000517CC;
      5'd12:   a = 32'sh00028BE6;
      5'd13:   a = 32'sh000145F3;
      5'd14:   a = 32'sh0000A2F9;
      5'd15:   a = 32'sh0000517D;
      5'd16:   a = 32'sh000028BE;
      5'd17:   a = 32'sh0000145F;
      5'd18:   a = 32'sh00000A30;
      5'd19:   a = 32'sh00000518;
      5'd20:   a = 32'sh0000028C;
      5'd21:   a = 32'sh00000146;
      5'd22:   a = 32'sh000000A3;
      5'd23:   a = 32'sh00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* hdl/scaled_cosine_sample_generator.sv */
// ----------------------------------------------------------------------------
// Scaled cosine sample generator
// Turns each Q16.16 time stamp into amplitude * cos(2*pi*(f*t + offset)),
// given as a signed Q9.15 sample, through a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at each rising edge with start high and busy low. busy
//   is held low: a new time stamp may enter on every clock cycle.
//   Each result is shown on out_sample_value and out_last_out for one cycle
//   with out_strobe high, in the order the words were taken. Throughput is
//   one sample per cycle. The pipeline has one stage for the frequency
//   multiply, one for the phase fold, one cell per CORDIC iteration (16),
//   one for rounding and one for the amplitude multiply.
//   The receiver cannot hold results off, so nothing here waits on it.
//   Configuration: cfg_we writes cfg_wdata into the register at cfg_index
//   (0 amplitude, 1 frequency, 2 phase offset); other indexes are ignored.
//   User must change registers only while no word is in flight; not enforced.
//   Reset (rst_n low at a clock edge) empties the pipeline and sets the
//   amplitude to 1.0, the frequency to 2.0 and the phase offset to zero.
// ----------------------------------------------------------------------------
module scaled_cosine_sample_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [scs_pkg::TIME_W-1:0]            in_time_stamp,
  input  logic                                  in_last_in,
  output logic                                  out_strobe,
  output logic signed [scs_pkg::SAMPLE_W-1:0]   out_sample_value,
  output logic                                  out_last_out,
  input  logic                                  cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scs_pkg::CFG_W-1:0]             cfg_wdata
);

  logic [scs_pkg::AMP_W-1:0]    amplitude_r;
  logic [scs_pkg::AMP_W-1:0]    amplitude_nxt;
  logic [scs_pkg::FREQ_W-1:0]   frequency_r;
  logic [scs_pkg::FREQ_W-1:0]   frequency_nxt;
  logic [scs_pkg::OFFSET_W-1:0] phase_offset_r;
  logic [scs_pkg::OFFSET_W-1:0] phase_offset_nxt;
  logic                         accept;

  logic                         chain_valid [scs_pkg::CELL_COUNT+1];
  scs_pkg::cordic_word_t        chain_word  [scs_pkg::CELL_COUNT+1];

  // Every cycle can take a word.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register decode.
  always_comb begin
    amplitude_nxt    = amplitude_r;
    frequency_nxt    = frequency_r;
    phase_offset_nxt = phase_offset_r;
    if (cfg_we) begin
      unique case (cfg_index)
        scs_pkg::CFG_AMPLITUDE:    amplitude_nxt    = cfg_wdata[scs_pkg::AMP_W-1:0];
        scs_pkg::CFG_FREQUENCY:    frequency_nxt    = cfg_wdata[scs_pkg::FREQ_W-1:0];
        scs_pkg::CFG_PHASE_OFFSET: phase_offset_nxt = cfg_wdata[scs_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r    <= scs_pkg::AMP_RESET;
      frequency_r    <= scs_pkg::FREQ_RESET;
      phase_offset_r <= scs_pkg::OFFSET_RESET;
    end else begin
      amplitude_r    <= amplitude_nxt;
      frequency_r    <= frequency_nxt;
      phase_offset_r <= phase_offset_nxt;
    end
  end

  // Phase computation and CORDIC seed.
  scs_phase u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .time_stamp   (in_time_stamp),
    .last_in      (in_last_in),
    .frequency    (frequency_r),
    .phase_offset (phase_offset_r),
    .seed_valid   (chain_valid[0]),
    .seed_word    (chain_word[0])
  );

  // Row of CORDIC cells, one iteration each.
  for (genvar g = 0; g < scs_pkg::CELL_COUNT; g++) begin : g_cell
    scs_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_idx  (scs_pkg::STEP_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_word   (chain_word[g]),
      .out_valid (chain_valid[g+1]),
      .out_word  (chain_word[g+1])
    );
  end

  // Rounding and amplitude scaling.
  scs_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_valid[scs_pkg::CELL_COUNT]),
    .in_word    (chain_word[scs_pkg::CELL_COUNT]),
    .amplitude  (signed'(amplitude_r)),
    .out_valid  (out_strobe),
    .out_sample (out_sample_value),
    .out_last   (out_last_out)
  );

endmodule

/* hdl/scs_phase.sv */
// ----------------------------------------------------------------------------
// Phase front end
// Forms the phase in turns from frequency times time plus the offset, folds
// it into a quadrant and a residual angle, and seeds the CORDIC chain.
// ----------------------------------------------------------------------------
module scs_phase (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [scs_pkg::TIME_W-1:0]          time_stamp,
  input  logic                                last_in,
  input  logic [scs_pkg::FREQ_W-1:0]          frequency,
  input  logic [scs_pkg::OFFSET_W-1:0]        phase_offset,
  output logic                                seed_valid,
  output scs_pkg::cordic_word_t               seed_word
);

  localparam int PB      = scs_pkg::PHASE_BITS;
  localparam int OFF_LSH = (PB >= 16) ? PB - 16 : 0;
  localparam int OFF_RSH = (PB >= 16) ? 0 : 16 - PB;

  logic                          mul_valid_r;
  logic                          mul_last_r;
  logic [scs_pkg::TIME_W-1:0]    frac_r;
  logic [scs_pkg::TIME_W-1:0]    frac_nxt;
  logic [PB-1:0]                 off_aligned;
  logic [PB-1:0]                 phase;
  logic                          seed_valid_r;
  scs_pkg::cordic_word_t         seed_word_r;
  scs_pkg::cordic_word_t         seed_word_nxt;

  function automatic logic [scs_pkg::TIME_W-1:0] in_product_low(
    input logic [scs_pkg::TIME_W-1:0] t,
    input logic [scs_pkg::FREQ_W-1:0] f
  );
    logic [scs_pkg::TIME_W-1:0] p;
    p = t * f;
    return p;
  endfunction

  // Only the fraction of frequency * time matters, so keep the low word.
  assign frac_nxt = in_product_low(time_stamp, frequency);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    frac_r     <= frac_nxt;
    mul_last_r <= last_in;
  end

  // Phase in turns, offset aligned to the phase resolution, modulo one turn.
  always_comb begin
    off_aligned = PB'((32'(phase_offset) << OFF_LSH) >> OFF_RSH);
    phase       = frac_r[scs_pkg::TIME_W-1 -: PB] + off_aligned;

    seed_word_nxt.last = mul_last_r;
    seed_word_nxt.quad = scs_pkg::quad_t'(phase[PB-1 -: 2]);
    seed_word_nxt.x    = scs_pkg::GAIN_Q30;
    seed_word_nxt.y    = '0;
    seed_word_nxt.z    = signed'(scs_pkg::CORDIC_W'(phase[PB-3:0]) << (32 - PB));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_valid_r <= 1'b0;
    end else begin
      seed_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    seed_word_r <= seed_word_nxt;
  end

  assign seed_valid = seed_valid_r;
  assign seed_word  = seed_word_r;

endmodule

/* hdl/scs_cordic_cell.sv */
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation with a registered result. The step index
// sets the shift and selects the arctangent constant.
// ----------------------------------------------------------------------------
module scs_cordic_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [scs_pkg::STEP_W-1:0]      step_idx,
  input  logic                            in_valid,
  input  scs_pkg::cordic_word_t           in_word,
  output logic                            out_valid,
  output scs_pkg::cordic_word_t           out_word
);

  logic signed [scs_pkg::CORDIC_W-1:0] dx;
  logic signed [scs_pkg::CORDIC_W-1:0] dy;
  logic signed [scs_pkg::CORDIC_W-1:0] angle;
  logic                                valid_r;
  scs_pkg::cordic_word_t               word_r;
  scs_pkg::cordic_word_t               word_nxt;

  // Arithmetic shifts give the floor of the scaled coordinates.
  always_comb begin
    dx    = in_word.y >>> step_idx;
    dy    = in_word.x >>> step_idx;
    angle = scs_pkg::atan_turn(step_idx);

    word_nxt      = in_word;
    if (!in_word.z[scs_pkg::CORDIC_W-1]) begin
      word_nxt.x = in_word.x - dx;
      word_nxt.y = in_word.y + dy;
      word_nxt.z = in_word.z - angle;
    end else begin
      word_nxt.x = in_word.x + dx;
      word_nxt.y = in_word.y - dy;
      word_nxt.z = in_word.z + angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

/* hdl/scs_scale.sv */
// ----------------------------------------------------------------------------
// Output scaler
// Maps the CORDIC vector to the cosine of the full phase, rounds it to
// Q1.15 with saturation and multiplies by the Q8.8 amplitude.
// ----------------------------------------------------------------------------
module scs_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  scs_pkg::cordic_word_t                 in_word,
  input  logic signed [scs_pkg::AMP_W-1:0]      amplitude,
  output logic                                  out_valid,
  output logic signed [scs_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                  out_last
);

  localparam int VW = scs_pkg::CORDIC_W + 1;
  localparam int RW = VW - 15;
  localparam int PW = scs_pkg::AMP_W + scs_pkg::COS_W;

  localparam logic signed [RW-1:0] COS_MAX = RW'(32767);
  localparam logic signed [RW-1:0] COS_MIN = -RW'(32768);

  logic signed [VW-1:0]                 sel;
  logic signed [VW-1:0]                 biased;
  logic signed [RW-1:0]                 rounded;
  logic signed [scs_pkg::COS_W-1:0]     cos_nxt;
  logic signed [scs_pkg::COS_W-1:0]     cos_r;
  logic                                 cos_valid_r;
  logic                                 cos_last_r;
  logic signed [PW-1:0]                 prod;
  logic signed [scs_pkg::SAMPLE_W-1:0]  sample_r;
  logic                                 sample_valid_r;
  logic                                 sample_last_r;

  // Quadrant fold, then round half up from Q2.30 to Q1.15 and saturate.
  always_comb begin
    unique case (in_word.quad)
      scs_pkg::QUAD_COS:     sel = VW'(in_word.x);
      scs_pkg::QUAD_NEG_SIN: sel = -VW'(in_word.y);
      scs_pkg::QUAD_NEG_COS: sel = -VW'(in_word.x);
      scs_pkg::QUAD_SIN:     sel = VW'(in_word.y);
      default:               sel = '0;
    endcase
    biased  = sel + VW'(16384);
    rounded = RW'(biased >>> 15);
    if (rounded > COS_MAX) begin
      cos_nxt = scs_pkg::COS_W'(COS_MAX);
    end else if (rounded < COS_MIN) begin
      cos_nxt = scs_pkg::COS_W'(COS_MIN);
    end else begin
      cos_nxt = scs_pkg::COS_W'(rounded);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_valid_r    <= 1'b0;
      sample_valid_r <= 1'b0;
    end else begin
      cos_valid_r    <= in_valid;
      sample_valid_r <= cos_valid_r;
    end
  end

  // Amplitude product; dropping eight bits is the floor to Q9.15.
  assign prod = amplitude * cos_r;

  always_ff @(posedge clk) begin
    cos_r         <= cos_nxt;
    cos_last_r    <= in_word.last;
    sample_r      <= prod[PW-1 -: scs_pkg::SAMPLE_W];
    sample_last_r <= cos_last_r;
  end

  assign out_valid  = sample_valid_r;
  assign out_sample = sample_r;
  assign out_last   = sample_last_r;

endmodule
